>>> rtl/spmmu_pkg.sv
// Shared types, codes and constants of the segment/page translator
package spmmu_pkg;

  // store geometry
  localparam int unsigned SegW      = 7;
  localparam int unsigned SegDepth  = 512;
  localparam int unsigned SegAw     = 9;
  localparam int unsigned PageW     = 12;
  localparam int unsigned PageDepth = 1024;
  localparam int unsigned PageAw    = 10;

  // access kinds
  localparam logic [1:0] FUNC_FETCH = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // result targets
  localparam logic [1:0] TGT_ROM = 2'd0;
  localparam logic [1:0] TGT_REG = 2'd1;
  localparam logic [1:0] TGT_MEM = 2'd2;
  localparam logic [1:0] TGT_ERR = 2'd3;

  // register selects on A2..A0
  localparam logic [2:0] SEL_PAGE_HI = 3'd0;
  localparam logic [2:0] SEL_PAGE_LO = 3'd1;
  localparam logic [2:0] SEL_SEG     = 3'd3;
  localparam logic [2:0] SEL_TASK    = 3'd5;
  localparam logic [2:0] SEL_CAUSE   = 3'd7;

  localparam logic [7:0] CAUSE_MARK = 8'h04;
  localparam logic [7:0] BUS_ERR_DATA = 8'hFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [19:0] address;
    logic [7:0]  wr_byte;
    logic        supervisor;
    logic        reset_button;
  } req_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] phys_address;
    logic [7:0]  rd_byte;
  } rsp_t;

  // architectural state seen by the resolve logic
  typedef struct packed {
    logic [3:0] cur_task;
    logic       boot_dis;
    logic       magic;
    logic [7:0] cause;
    logic       parity;
  } state_t;

  // state updates produced by one transaction
  typedef struct packed {
    logic             page_we;
    logic [PageW-1:0] page_wdata;
    logic             task_we;
    logic [3:0]       cur_task;
    logic             boot_dis;
    logic             magic;
    logic             cause_we;
    logic [7:0]       cause;
  } upd_t;

  // interference term: user access that is not a plain fetch, or any user access in magic mode
  function automatic logic ifc_active(logic [1:0] func, logic sup, logic magic);
    return (magic || (func != FUNC_FETCH)) && !sup;
  endfunction

endpackage

>>> rtl/spmmu_ram.sv
// Generic single write port RAM with registered, enabled read
module spmmu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, holds its data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/spmmu_resolve.sv
// Routing, register read/write decode and translation result of one transaction
module spmmu_resolve (
  input  spmmu_pkg::req_t   req_i,
  input  spmmu_pkg::state_t st_i,
  input  logic [6:0]        seg_i,
  input  logic [11:0]       page_i,
  output spmmu_pkg::rsp_t   rsp_o,
  output spmmu_pkg::upd_t   upd_o
);
  import spmmu_pkg::*;

  logic       is_wr;
  logic       ifc;
  logic       a19;
  logic       is_rom;
  logic       is_reg;
  logic [2:0] sel;
  logic [7:0] d;
  logic [7:0] cause_rd;

  assign is_wr  = (req_i.func == FUNC_WRITE);
  assign ifc    = ifc_active(req_i.func, req_i.supervisor, st_i.magic);
  assign a19    = req_i.address[19];
  // boot rom takes reads below 128K while boot is enabled
  assign is_rom = !is_wr && !st_i.boot_dis && (req_i.address[19:17] == 3'b000);
  assign is_reg = !is_rom && a19 && !ifc;
  assign sel    = req_i.address[2:0];
  assign d      = req_i.wr_byte;

  assign cause_rd = {6'b0, 1'b1, req_i.reset_button} | (st_i.parity ? 8'h00 : st_i.cause);

  always_comb begin
    rsp_o = '0;
    upd_o = '0;
    upd_o.page_wdata = page_i;
    upd_o.cur_task   = st_i.cur_task;
    upd_o.boot_dis   = st_i.boot_dis;
    upd_o.magic      = st_i.magic;
    upd_o.cause      = st_i.cause;
    if (is_rom) begin
      rsp_o.target       = TGT_ROM;
      rsp_o.phys_address = {7'b0, req_i.address[13:0]};
    end else if (is_reg) begin
      rsp_o.target = TGT_REG;
      if (is_wr) begin
        // register writes; the segment write happens one stage earlier
        case (sel)
          SEL_PAGE_HI: begin
            upd_o.page_we    = 1'b1;
            upd_o.page_wdata = {d[7], d[6], d[1:0], page_i[7:0]};
          end
          SEL_PAGE_LO: begin
            upd_o.page_we    = 1'b1;
            upd_o.page_wdata = {page_i[11:8], d};
          end
          SEL_TASK: begin
            upd_o.task_we  = 1'b1;
            upd_o.cur_task = d[3:0];
            upd_o.boot_dis = !d[6];
            upd_o.magic    = !d[7];
          end
          default: ;
        endcase
      end else begin
        // register reads
        case (sel)
          SEL_PAGE_HI: rsp_o.rd_byte = {page_i[11], page_i[10], {4{page_i[9]}},
                                        page_i[9:8]};
          SEL_PAGE_LO: rsp_o.rd_byte = page_i[7:0];
          SEL_SEG:     rsp_o.rd_byte = {!st_i.magic, seg_i};
          SEL_CAUSE:   rsp_o.rd_byte = cause_rd;
          default:     rsp_o.rd_byte = 8'h00;
        endcase
      end
    end else begin
      // translated access, cause recorded even on a bus error
      upd_o.cause_we = 1'b1;
      upd_o.cause    = {3'b0, req_i.address[17:13]} | CAUSE_MARK;
      if (page_i[11] || (is_wr && !page_i[10])) begin
        rsp_o.target  = TGT_ERR;
        rsp_o.rd_byte = is_wr ? 8'h00 : BUS_ERR_DATA;
      end else begin
        rsp_o.target       = TGT_MEM;
        rsp_o.phys_address = {page_i[9:0], req_i.address[10:0]};
      end
    end
  end

endmodule

>>> rtl/segment_page_mmu_translator_top.sv
// Top level of the segment/page translator: control, stores and result register
//
// A transaction is taken while the one before it resolves, if the result side
// keeps up, but not while one is in the page read stage: the accept cycle
// starts the segment store read, the next cycle uses that entry to read the
// page store (and performs a segment register write), and the resolve stage
// resolves the access into the result register while the next is accepted;
// the two dependent store reads set this spacing. After reset a clearing pass
// sets every segment and page entry to all ones; no transaction is accepted
// during it, while configuration writes are taken at any time. Result fields:
// target, physical address (or boot ROM offset) and the register read byte.
module segment_page_mmu_translator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spmmu_pkg::req_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spmmu_pkg::rsp_t   out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);
  import spmmu_pkg::*;

  logic              clr_busy_q, clr_busy_d;
  logic [PageAw-1:0] clr_q, clr_d;
  logic              s1_q, s1_d;
  logic              s2_q, s2_d;
  logic              out_valid_q, out_valid_d;
  logic [3:0]        task_q, task_d;
  logic              boot_dis_q, boot_dis_d;
  logic              magic_q, magic_d;
  logic [7:0]        cause_q, cause_d;
  logic              parity_q, parity_d;
  req_t              req_q;
  rsp_t              out_q;
  logic [SegAw-1:0]  seg_idx_q;

  logic              in_acc;
  logic              fin_go;
  logic              ic;
  logic              a19;
  logic [3:0]        idx_task;
  logic              s19;
  logic [SegAw-1:0]  seg_idx;
  logic [SegW-1:0]   seg_rdata;
  logic [PageW-1:0]  page_rdata;
  logic [PageAw-1:0] page_idx;
  logic              seg_wr;
  logic              seg_we;
  logic [SegAw-1:0]  seg_waddr;
  logic [SegW-1:0]   seg_wdata;
  logic              page_we;
  logic [PageAw-1:0] page_waddr;
  logic [PageW-1:0]  page_wdata;
  state_t            st;
  rsp_t              rsp;
  upd_t              upd;

  // handshakes
  assign fin_go      = s2_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !clr_busy_q && !s1_q && (!s2_q || fin_go);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

  // segment index at accept, with task and magic forwarded from the finishing transaction
  assign a19      = in_i.address[19];
  assign ic       = !in_i.supervisor && (magic_d || (in_i.func != FUNC_FETCH) || a19);
  assign idx_task = (a19 || ic) ? task_d : 4'd0;
  assign s19      = a19 && (ic || in_i.address[8]);
  assign seg_idx  = {idx_task, s19, in_i.address[18:15]};

  // page index from the segment entry
  assign page_idx = {seg_rdata[5:0], req_q.address[14:11]};

  // segment register write in the page read stage
  assign seg_wr = s1_q && (req_q.func == FUNC_WRITE) && req_q.supervisor &&
                  req_q.address[19] && (req_q.address[2:0] == SEL_SEG);

  // store write ports, the clearing pass has priority
  assign seg_we     = clr_busy_q || seg_wr;
  assign seg_waddr  = clr_busy_q ? clr_q[SegAw-1:0] : seg_idx_q;
  assign seg_wdata  = clr_busy_q ? {SegW{1'b1}} : req_q.wr_byte[SegW-1:0];
  assign page_we    = clr_busy_q || (fin_go && upd.page_we);
  assign page_waddr = clr_busy_q ? clr_q : page_idx;
  assign page_wdata = clr_busy_q ? {PageW{1'b1}} : upd.page_wdata;

  spmmu_ram #(
    .Width (SegW),
    .Depth (SegDepth)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .re_i    (in_acc),
    .raddr_i (seg_idx),
    .rdata_o (seg_rdata)
  );

  spmmu_ram #(
    .Width (PageW),
    .Depth (PageDepth)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (page_we),
    .waddr_i (page_waddr),
    .wdata_i (page_wdata),
    .re_i    (s1_q),
    .raddr_i (page_idx),
    .rdata_o (page_rdata)
  );

  assign st.cur_task = task_q;
  assign st.boot_dis = boot_dis_q;
  assign st.magic    = magic_q;
  assign st.cause    = cause_q;
  assign st.parity   = parity_q;

  spmmu_resolve u_resolve (
    .req_i  (req_q),
    .st_i   (st),
    .seg_i  (seg_rdata),
    .page_i (page_rdata),
    .rsp_o  (rsp),
    .upd_o  (upd)
  );

  // next state of control and unit registers
  always_comb begin
    clr_busy_d  = clr_busy_q;
    clr_d       = clr_q;
    if (clr_busy_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == PageAw'(PageDepth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    s1_d        = in_acc;
    s2_d        = s1_q || (s2_q && !fin_go);
    out_valid_d = fin_go || (out_valid_q && !out_ready_i);
    task_d      = (fin_go && upd.task_we) ? upd.cur_task : task_q;
    boot_dis_d  = (fin_go && upd.task_we) ? upd.boot_dis : boot_dis_q;
    magic_d     = (fin_go && upd.task_we) ? upd.magic : magic_q;
    cause_d     = (fin_go && upd.cause_we) ? upd.cause : cause_q;
    parity_d    = cfg_valid_i ? cfg_data_i : parity_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_q       <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      task_q      <= '0;
      boot_dis_q  <= 1'b0;
      magic_q     <= 1'b0;
      cause_q     <= '0;
      parity_q    <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_q       <= clr_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= out_valid_d;
      task_q      <= task_d;
      boot_dis_q  <= boot_dis_d;
      magic_q     <= magic_d;
      cause_q     <= cause_d;
      parity_q    <= parity_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= in_i;
      seg_idx_q <= seg_idx;
    end
    if (fin_go) begin
      out_q <= rsp;
    end
  end

  // no transaction enters while the stores are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !in_acc)
    else $error("transaction accepted during clearing pass");

  // at most one transaction is in flight between accept and result
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(s1_q && s2_q))
    else $error("two transactions in flight");

  // the page read stage always hands on to the resolve stage
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_q |=> s2_q)
    else $error("page read stage lost a transaction");

  // a resolved transaction shows up in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni) fin_go |=> out_valid_q)
    else $error("resolved transaction not presented");

endmodule

>>> dv/segment_page_mmu_translator_top_tb.sv
// Self-checking testbench for the segment/page translator top level
`timescale 1ns / 100ps

module segment_page_mmu_translator_top_tb;
  import spmmu_pkg::*;

  // undefined access kind, handled by the block as a data read
  localparam logic [1:0]  FUNC_UNDEF  = 2'd3;
  // register select with no register behind it
  localparam logic [2:0]  SEL_UNUSED  = 3'd2;
  localparam logic [19:0] REG_WIN     = 20'h80000;
  localparam logic [19:0] ROM_LIMIT   = 20'h20000;
  localparam int          PG_WE_BIT   = 10;
  localparam int          PG_NONX_BIT = 11;

  localparam int DIR_ROWS       = 26;
  localparam int RAND_PER_PHASE = 500;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 150;
  localparam int STALL_LIMIT    = 4000;

  typedef struct packed {
    req_t acc;
    logic typed;
    rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  req_t in_req    = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data  = 1'b0;

  // typed expectation travelling with the transaction on the input side
  logic row_typed = 1'b0;
  rsp_t row_rsp   = '0;

  // predictor state
  bit [6:0]  seg_tbl [SegDepth];
  bit [11:0] pg_tbl [PageDepth];
  bit [3:0]  cur_task;
  bit        boot_off;
  bit        magic_q;
  bit [7:0]  cause_q;
  bit        parity_q;

  rsp_t        pending_rsp_q [$];
  dir_row_t    dir_tbl [DIR_ROWS];
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_err       = 0;
  int unsigned idle_cycles = 0;
  int unsigned tgt_hits [4] = '{default: 0};

  segment_page_mmu_translator_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // user access that is not a plain fetch, or any user access in magic mode
  function automatic bit user_interf(input logic [1:0] f, input logic sup);
    return (magic_q || (f != FUNC_FETCH)) && !sup;
  endfunction

  function automatic bit [8:0] seg_slot(input logic [19:0] a, input logic [1:0] f,
                                        input logic sup);
    bit       ic;
    bit [3:0] tk;
    bit       s19;
    ic  = user_interf(f, sup);
    tk  = (a[19] || ic) ? cur_task : 4'd0;
    s19 = a[19] && (ic || a[8]);
    return {tk, s19, a[18:15]};
  endfunction

  function automatic bit [9:0] page_slot(input logic [19:0] a, input logic [1:0] f,
                                         input logic sup);
    return {seg_tbl[seg_slot(a, f, sup)][5:0], a[14:11]};
  endfunction

  // routes one access and applies its side effects to the predictor state
  function automatic rsp_t resolve_access(input req_t r);
    rsp_t        res;
    logic [1:0]  f;
    logic [19:0] a;
    logic [11:0] pg;
    bit   [9:0]  pi;
    res = '0;
    a   = r.address;
    f   = (r.func == FUNC_UNDEF) ? FUNC_READ : r.func;
    if (f != FUNC_WRITE && !boot_off && a < ROM_LIMIT) begin
      res.target       = TGT_ROM;
      res.phys_address = 21'(a[13:0]);
    end else if (a[19] && !user_interf(f, r.supervisor)) begin
      res.target = TGT_REG;
      if (f == FUNC_WRITE) begin
        case (a[2:0])
          SEL_PAGE_HI: begin
            pi = page_slot(a, FUNC_WRITE, r.supervisor);
            pg_tbl[pi] = {r.wr_byte[7], r.wr_byte[6], r.wr_byte[1:0],
                          pg_tbl[pi][7:0]};
          end
          SEL_PAGE_LO: begin
            pi = page_slot(a, FUNC_WRITE, r.supervisor);
            pg_tbl[pi][7:0] = r.wr_byte;
          end
          SEL_SEG: seg_tbl[seg_slot(a, FUNC_WRITE, r.supervisor)] = r.wr_byte[6:0];
          SEL_TASK: begin
            cur_task = r.wr_byte[3:0];
            boot_off = ~r.wr_byte[6];
            magic_q  = ~r.wr_byte[7];
          end
          default: ;
        endcase
      end else begin
        case (a[2:0])
          SEL_PAGE_HI: begin
            pg = pg_tbl[page_slot(a, FUNC_READ, r.supervisor)];
            res.rd_byte = {pg[PG_NONX_BIT], pg[PG_WE_BIT], {4{pg[9]}}, pg[9:8]};
          end
          SEL_PAGE_LO: res.rd_byte = pg_tbl[page_slot(a, FUNC_READ, r.supervisor)][7:0];
          SEL_SEG: res.rd_byte = {~magic_q, seg_tbl[seg_slot(a, FUNC_READ, r.supervisor)]};
          SEL_CAUSE: res.rd_byte = {6'b0, 1'b1, r.reset_button} | (parity_q ? 8'h00 : cause_q);
          default: res.rd_byte = 8'h00;
        endcase
      end
    end else begin
      // translation records cause even when it ends in a bus error
      pg = pg_tbl[page_slot(a, f, r.supervisor)];
      cause_q = {3'b000, a[17:13]} | CAUSE_MARK;
      if (pg[PG_NONX_BIT] || (f == FUNC_WRITE && !pg[PG_WE_BIT])) begin
        res.target = TGT_ERR;
        if (f != FUNC_WRITE) res.rd_byte = BUS_ERR_DATA;
      end else begin
        res.target       = TGT_MEM;
        res.phys_address = {pg[9:0], a[10:0]};
      end
    end
    return res;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] f, input logic [19:0] a,
                                      input logic [7:0] d, input int sup, input int rb,
                                      input int typed, input logic [1:0] tgt,
                                      input logic [20:0] phys, input logic [7:0] rd);
    dir_row_t row;
    row.acc.func         = f;
    row.acc.address      = a;
    row.acc.wr_byte      = d;
    row.acc.supervisor   = 1'(sup);
    row.acc.reset_button = 1'(rb);
    row.typed            = 1'(typed);
    row.rsp.target       = tgt;
    row.rsp.phys_address = phys;
    row.rsp.rd_byte      = rd;
    return row;
  endfunction

  // mostly well-formed setup and translated traffic, some raw noise
  function automatic req_t random_access();
    req_t        r;
    int unsigned pick;
    pick           = $urandom_range(0, 99);
    r.func         = 2'($urandom_range(0, 3));
    r.address      = 20'($urandom);
    r.wr_byte      = 8'($urandom);
    r.supervisor   = 1'($urandom);
    r.reset_button = 1'($urandom);
    // narrow window so written mappings get hit again
    if (pick < 90) r.address[18:17] = 2'b00;
    if (pick < 8) begin
      // task switch: few tasks, boot mostly off
      r.func          = FUNC_WRITE;
      r.supervisor    = 1'b1;
      r.address[19]   = 1'b1;
      r.address[2:0]  = SEL_TASK;
      r.wr_byte[3:2]  = 2'b00;
      r.wr_byte[6]    = ($urandom_range(0, 3) == 0);
    end else if (pick < 20) begin
      // segment entry, mostly pointing at a small group of pages
      r.func         = FUNC_WRITE;
      r.supervisor   = 1'b1;
      r.address[19]  = 1'b1;
      r.address[2:0] = SEL_SEG;
      if ($urandom_range(0, 3) != 0) r.wr_byte[5:3] = 3'b000;
    end else if (pick < 36) begin
      // page entry, mostly present
      r.func         = FUNC_WRITE;
      r.supervisor   = 1'b1;
      r.address[19]  = 1'b1;
      r.address[2:0] = ($urandom_range(0, 1) == 0) ? SEL_PAGE_HI : SEL_PAGE_LO;
      r.wr_byte[7]   = ($urandom_range(0, 5) == 0);
    end else if (pick < 46) begin
      // register reads, user fetches among them
      if (r.func == FUNC_WRITE) r.func = FUNC_READ;
      r.address[19] = 1'b1;
      if (r.func != FUNC_FETCH) r.supervisor = 1'b1;
    end
    return r;
  endfunction

  // offer one transaction and hold it until taken
  task automatic send_access(input req_t r, input logic typed, input rsp_t typed_rsp);
    int unsigned gap;
    gap = ((n_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_req    <= r;
    row_typed <= typed;
    row_rsp   <= typed_rsp;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic write_parity(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_checked != n_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int unsigned stall;
    int unsigned n_rx;
    n_rx = 0;
    @(posedge rst_n);
    forever begin
      if (n_rx == HOLD_AT) stall = HOLD_CYCLES;
      else if ((n_rx / 48) % 4 == 2) stall = 0;
      else stall = $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_rx++;
    end
  end

  // compare results, then predict newly accepted transactions
  always @(posedge clk) begin : scoreboard
    rsp_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (cfg_valid && cfg_ready) parity_q = cfg_data;
      if (out_valid && out_ready) begin
        tgt_hits[out_rsp.target]++;
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected result target %0d phys %h data %h", $time,
                   out_rsp.target, out_rsp.phys_address, out_rsp.rd_byte);
          n_err++;
        end else begin
          want = pending_rsp_q.pop_front();
          n_checked++;
          if (want.target != out_rsp.target) begin
            $display("%0t: target expected %0d actual %0d", $time,
                     want.target, out_rsp.target);
            n_err++;
          end
          if (want.phys_address != out_rsp.phys_address) begin
            $display("%0t: phys_address expected %h actual %h", $time,
                     want.phys_address, out_rsp.phys_address);
            n_err++;
          end
          if (want.rd_byte != out_rsp.rd_byte) begin
            $display("%0t: rd_byte expected %h actual %h", $time,
                     want.rd_byte, out_rsp.rd_byte);
            n_err++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = resolve_access(in_req);
        pending_rsp_q.push_back(row_typed ? row_rsp : want);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("segment_page_mmu_translator_top verification failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int ph;
    foreach (seg_tbl[i]) seg_tbl[i] = '1;
    foreach (pg_tbl[i]) pg_tbl[i] = '1;
    cur_task = '0;
    boot_off = 1'b0;
    magic_q  = 1'b0;
    cause_q  = '0;
    parity_q = 1'b0;

    // directed rows; untyped rows go to the predictor
    dir_tbl[0]  = mk_row(FUNC_FETCH, 20'h00000, 8'h00, 0, 0, 1, TGT_ROM, 21'h0000, 8'h00);
    dir_tbl[1]  = mk_row(FUNC_READ,  20'h1FFFF, 8'hFF, 1, 1, 1, TGT_ROM, 21'h3FFF, 8'h00);
    // boot rom never takes a write; unmapped page
    dir_tbl[2]  = mk_row(FUNC_WRITE, 20'h00000, 8'hAA, 0, 0, 1, TGT_ERR, 21'h0, 8'h00);
    dir_tbl[3]  = mk_row(FUNC_READ,  REG_WIN + SEL_CAUSE, 8'h00, 1, 1, 1, TGT_REG, 21'h0, 8'h07);
    // user fetch reaches the registers while magic mode is off
    dir_tbl[4]  = mk_row(FUNC_FETCH, REG_WIN + SEL_CAUSE, 8'h00, 0, 0, 1, TGT_REG, 21'h0, 8'h06);
    dir_tbl[5]  = mk_row(FUNC_READ,  20'hFFFFF, 8'h00, 0, 0, 1, TGT_ERR, 21'h0, 8'hFF);
    dir_tbl[6]  = mk_row(FUNC_READ,  REG_WIN + SEL_CAUSE, 8'h00, 1, 0, 1, TGT_REG, 21'h0, 8'h1F);
    dir_tbl[7]  = mk_row(FUNC_READ,  REG_WIN + SEL_SEG, 8'h00, 1, 0, 1, TGT_REG, 21'h0, 8'hFF);
    dir_tbl[8]  = mk_row(FUNC_READ,  REG_WIN + SEL_PAGE_HI, 8'h00, 1, 0, 1, TGT_REG, 21'h0, 8'hFF);
    dir_tbl[9]  = mk_row(FUNC_READ,  REG_WIN + SEL_PAGE_LO, 8'h00, 1, 0, 1, TGT_REG, 21'h0, 8'hFF);
    // task register is write only
    dir_tbl[10] = mk_row(FUNC_READ,  REG_WIN + SEL_TASK, 8'h00, 1, 0, 1, TGT_REG, 21'h0, 8'h00);
    dir_tbl[11] = mk_row(FUNC_READ,  REG_WIN + SEL_UNUSED, 8'h00, 1, 0, 1, TGT_REG, 21'h0, 8'h00);
    // task 3, boot off, magic on
    dir_tbl[12] = mk_row(FUNC_WRITE, REG_WIN + SEL_TASK, 8'h03, 1, 0, 1, TGT_REG, 21'h0, 8'h00);
    dir_tbl[13] = mk_row(FUNC_WRITE, REG_WIN + SEL_SEG, 8'h05, 1, 0, 1, TGT_REG, 21'h0, 8'h00);
    dir_tbl[14] = mk_row(FUNC_WRITE, REG_WIN + SEL_PAGE_LO, 8'h34, 1, 0, 1, TGT_REG, 21'h0, 8'h00);
    dir_tbl[15] = mk_row(FUNC_WRITE, REG_WIN + SEL_PAGE_HI, 8'h42, 1, 0, 1, TGT_REG, 21'h0, 8'h00);
    dir_tbl[16] = mk_row(FUNC_READ,  REG_WIN + SEL_PAGE_HI, 8'h00, 1, 0, 0, TGT_ROM, 21'h0, 8'h00);
    dir_tbl[17] = mk_row(FUNC_READ,  REG_WIN + SEL_SEG, 8'h00, 1, 0, 0, TGT_ROM, 21'h0, 8'h00);
    dir_tbl[18] = mk_row(FUNC_WRITE, 20'h00000, 8'h5A, 0, 0, 0, TGT_ROM, 21'h0, 8'h00);
    dir_tbl[19] = mk_row(FUNC_FETCH, 20'h007FF, 8'h00, 0, 1, 0, TGT_ROM, 21'h0, 8'h00);
    // supervisor access below the register window with boot off
    dir_tbl[20] = mk_row(FUNC_READ,  20'h00000, 8'h00, 1, 0, 1, TGT_ERR, 21'h0, 8'hFF);
    // user fetch in magic mode is translated
    dir_tbl[21] = mk_row(FUNC_FETCH, REG_WIN + SEL_PAGE_HI, 8'h00, 0, 0, 1, TGT_ERR, 21'h0, 8'hFF);
    dir_tbl[22] = mk_row(FUNC_UNDEF, REG_WIN + SEL_CAUSE, 8'h00, 1, 1, 1, TGT_REG, 21'h0, 8'h07);
    // cause register ignores writes
    dir_tbl[23] = mk_row(FUNC_WRITE, 20'hFFFFF, 8'hFF, 1, 0, 1, TGT_REG, 21'h0, 8'h00);
    // mark the page non-existent, then hit it
    dir_tbl[24] = mk_row(FUNC_WRITE, REG_WIN + SEL_PAGE_HI, 8'h80, 1, 0, 1, TGT_REG, 21'h0, 8'h00);
    dir_tbl[25] = mk_row(FUNC_WRITE, 20'h00000, 8'hFF, 0, 0, 1, TGT_ERR, 21'h0, 8'h00);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_parity(1'b0);
    foreach (dir_tbl[i]) send_access(dir_tbl[i].acc, dir_tbl[i].typed, dir_tbl[i].rsp);
    in_valid <= 1'b0;
    wait_drained();

    // random phases with the parity test bit toggled between them
    for (ph = 0; ph < 3; ph++) begin
      write_parity(~ph[0]);
      repeat (RAND_PER_PHASE) send_access(random_access(), 1'b0, '0);
      in_valid <= 1'b0;
      wait_drained();
    end

    $display("run covered %0d transactions under both parity test settings, %0d results checked",
             n_sent, n_checked);
    $display("targets seen: boot rom %0d, registers %0d, memory %0d, bus error %0d",
             tgt_hits[TGT_ROM], tgt_hits[TGT_REG], tgt_hits[TGT_MEM], tgt_hits[TGT_ERR]);
    if (n_err == 0 && pending_rsp_q.size() == 0) begin
      $display("segment_page_mmu_translator_top verification clean");
    end else begin
      $display("segment_page_mmu_translator_top verification failed");
    end
    $finish;
  end

endmodule
